FILE: rtl/iiee_pkg.sv
// iiee_pkg: shared types, codes and constants for the expression evaluator
// used by all modules in rtl; no dependencies
package iiee_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int DIV_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   localparam logic [1:0] TYPE_NUMBER = 2'd0;
   localparam logic [1:0] TYPE_OP = 2'd1;
   localparam logic [1:0] TYPE_BAD = 2'd2;
   localparam logic [1:0] TYPE_SPARE = 2'd3;

   localparam logic [3:0] OP_PLUS = 4'd0;
   localparam logic [3:0] OP_MINUS = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_MOD = 4'd4;
   localparam logic [3:0] OP_EQ = 4'd5;
   localparam logic [3:0] OP_LE = 4'd8;
   localparam logic [3:0] OP_GE = 4'd10;
   localparam logic [3:0] OP_OTHER = 4'd11;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;

   localparam logic [2:0] CMP_EQ = 3'd0;
   localparam logic [2:0] CMP_NE = 3'd1;
   localparam logic [2:0] CMP_LT = 3'd2;
   localparam logic [2:0] CMP_LE = 3'd3;
   localparam logic [2:0] CMP_GT = 3'd4;
   localparam logic [2:0] CMP_GE = 3'd5;

   localparam logic [3:0] ERR_OK = 4'd0;
   localparam logic [3:0] ERR_BAD = 4'd1;
   localparam logic [3:0] ERR_LEAD = 4'd2;
   localparam logic [3:0] ERR_SYNTAX = 4'd3;
   localparam logic [3:0] ERR_DIV0 = 4'd4;
   localparam logic [3:0] ERR_MOD0 = 4'd5;
   localparam logic [3:0] ERR_NOCMP = 4'd6;
   localparam logic [3:0] ERR_MANYCMP = 4'd7;
   localparam logic [3:0] ERR_MISSING = 4'd8;

   // controller to datapath
   typedef struct packed {
      logic take;      // latch the token into the datapath
      logic div_start; // begin the iterative divide
      logic div_step;  // one restoring step
      logic apply;     // apply the token to state
      logic emit;      // load output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } status_type;

endpackage

FILE: rtl/iiee_divider.sv
// iiee_divider: iterative signed divide and modulo, one quotient bit per step
// depends on iiee_pkg
module iiee_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            step,
   input  logic [iiee_pkg::VALUE_WIDTH-1:0] dividend,
   input  logic [iiee_pkg::VALUE_WIDTH-1:0] divisor,
   output logic                            done,
   output logic [iiee_pkg::VALUE_WIDTH-1:0] quotient,
   output logic [iiee_pkg::VALUE_WIDTH-1:0] remainder
);
   import iiee_pkg::*;

   localparam int W = VALUE_WIDTH;

   logic [W-1:0] q_ff, q_in, d_ff, d_in;
   logic [W:0] r_ff, r_in, trial;
   logic na_ff, na_in, nq_ff, nq_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [W-1:0] ma, mb;

   always_comb begin
      ma = dividend[W-1] ? (~dividend + 1'b1) : dividend;
      mb = divisor[W-1] ? (~divisor + 1'b1) : divisor;
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      na_in = na_ff;
      nq_in = nq_ff;
      cnt_in = cnt_ff;
      trial = {r_ff[W-1:0], q_ff[W-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = ma;
         r_in = '0;
         d_in = mb;
         na_in = dividend[W-1];
         nq_in = dividend[W-1] ^ divisor[W-1];
         cnt_in = DIV_CNT_WIDTH'(W);
      end else if (step && cnt_ff != '0) begin
         if (!trial[W]) begin
            r_in = trial;
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[W-1:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      na_ff <= na_in;
      nq_ff <= nq_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign done = (cnt_ff == '0);
   assign quotient = nq_ff ? (~q_ff + 1'b1) : q_ff;
   assign remainder = na_ff ? (~r_ff[W-1:0] + 1'b1) : r_ff[W-1:0];

endmodule

FILE: rtl/iiee_datapath.sv
// iiee_datapath: side evaluation state, comparison and result register
// depends on iiee_pkg and iiee_divider
module iiee_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  iiee_pkg::cmd_type               cmd,
   output iiee_pkg::status_type            status,
   input  logic [1:0]                      req_type,
   input  logic [iiee_pkg::VALUE_WIDTH-1:0] req_token_value,
   input  logic [3:0]                      req_op_code,
   input  logic                            req_is_condition,
   input  logic                            req_last_token,
   output logic                            tok_last,
   output logic [iiee_pkg::VALUE_WIDTH-1:0] rsp_expr_value,
   output logic                            rsp_cond_true,
   output logic [3:0]                      rsp_error_code
);
   import iiee_pkg::*;

   localparam int W = VALUE_WIDTH;

   // latched token
   logic [1:0] ty_ff;
   logic [W-1:0] tv_ff;
   logic [3:0] op_ff;
   logic cond_ff, last_ff;

   logic [W-1:0] sum_ff, sum_in, term_ff, term_in, left_ff, left_in;
   logic [3:0] pend_ff, pend_in;
   logic expv_ff, expv_in, tminus_ff, tminus_in;
   logic [1:0] cnt_ff, cnt_in, ccount_ff, ccount_in;
   logic [2:0] ckind_ff, ckind_in;
   logic [7:0] ef_ff, ef_in;
   logic [3:0] lerr_ff, lerr_in;
   logic lempty_ff, lempty_in, mode_ff, mode_in, start_ff, start_in;

   logic [W-1:0] out_v_ff;
   logic out_t_ff;
   logic [3:0] out_e_ff;

   logic div_done;
   logic [W-1:0] quo, rem;

   // flag bits
   localparam int F_BAD = 0, F_LEAD = 1, F_MSYN = 2, F_DIV0 = 3, F_MOD0 = 4, F_ADD = 5;

   iiee_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .step(cmd.div_step),
      .dividend(term_ff), .divisor(tv_ff), .done(div_done),
      .quotient(quo), .remainder(rem)
   );

   function automatic logic is_mult(input logic [3:0] c);
      return (c == OP_MUL) || (c == OP_DIV) || (c == OP_MOD);
   endfunction

   function automatic logic slt(input logic [W-1:0] a, input logic [W-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

   logic [3:0] op_n;
   logic mode_now, is_cmp;
   logic [3:0] sc;
   logic [W-1:0] sv, closed, ev;
   logic truth;
   logic [3:0] ecode;

   assign op_n = (op_ff > OP_OTHER) ? OP_OTHER : op_ff;
   assign mode_now = start_ff ? mode_ff : cond_ff;
   assign is_cmp = mode_now && ty_ff == TYPE_OP && op_n >= OP_EQ && op_n <= OP_GE;
   assign status.need_div = ty_ff == TYPE_NUMBER && cnt_ff != 2'd0 && expv_ff
                            && (pend_ff == OP_DIV || pend_ff == OP_MOD) && tv_ff != '0
                            && !is_cmp && !(mode_now && ccount_ff >= 2'd2);
   assign status.div_done = div_done;
   assign tok_last = last_ff;

   always_comb begin
      logic mf;
      mf = 1'b0;
      sum_in = sum_ff; term_in = term_ff; left_in = left_ff;
      pend_in = pend_ff; expv_in = expv_ff; tminus_in = tminus_ff;
      cnt_in = cnt_ff; ccount_in = ccount_ff; ckind_in = ckind_ff;
      ef_in = ef_ff; lerr_in = lerr_ff; lempty_in = lempty_ff;
      mode_in = mode_now; start_in = 1'b1;
      closed = tminus_ff ? sum_ff - term_ff : sum_ff + term_ff;
      // side finish on current state
      if (ef_ff[F_BAD]) sc = ERR_BAD;
      else if (ef_ff[F_LEAD] || expv_ff) sc = ERR_LEAD;
      else if (ef_ff[F_MSYN]) sc = ERR_SYNTAX;
      else if (ef_ff[F_DIV0]) sc = ERR_DIV0;
      else if (ef_ff[F_MOD0]) sc = ERR_MOD0;
      else if (ef_ff[F_ADD]) sc = ERR_SYNTAX;
      else sc = ERR_OK;
      sv = (sc == ERR_OK) ? closed : '0;
      if (is_cmp) begin
         if (ccount_ff == 2'd0) begin
            lempty_in = cnt_ff == 2'd0;
            left_in = sv;
            lerr_in = sc;
            ckind_in = 3'(op_n - OP_EQ);
            ccount_in = 2'd1;
            sum_in = '0; term_in = '0; pend_in = OP_PLUS; expv_in = 1'b1;
            cnt_in = 2'd0; ef_in = '0; tminus_in = 1'b0;
         end else begin
            ccount_in = 2'd2;
         end
      end else if (mode_now && ccount_ff >= 2'd2) begin
         cnt_in = cnt_ff;
      end else if (ty_ff == TYPE_NUMBER) begin
         if (cnt_ff == 2'd0) begin
            sum_in = '0; tminus_in = 1'b0; term_in = tv_ff;
         end else if (!expv_ff) begin
            ef_in[F_ADD] = 1'b1; term_in = tv_ff;
         end else if (pend_ff == OP_MUL) begin
            term_in = W'(term_ff * tv_ff);
         end else if (is_mult(pend_ff)) begin
            if (tv_ff == '0) begin
               if (ef_ff[4:2] == 3'b000) begin
                  if (pend_ff == OP_DIV) ef_in[F_DIV0] = 1'b1;
                  else ef_in[F_MOD0] = 1'b1;
               end
            end else begin
               term_in = (pend_ff == OP_MOD) ? rem : quo;
            end
         end else begin
            term_in = tv_ff;
         end
         expv_in = 1'b0;
         if (cnt_ff < 2'd2) cnt_in = cnt_ff + 1'b1;
      end else if (ty_ff == TYPE_OP) begin
         if (cnt_ff == 2'd0) begin
            ef_in[F_LEAD] = 1'b1;
         end else if (expv_ff) begin
            if (is_mult(pend_ff) && ef_in[4:2] == 3'b000) ef_in[F_MSYN] = 1'b1;
            mf = (ef_in[4:2] == 3'b000);
            if (is_mult(op_n)) begin
               if (mf) ef_in[F_MSYN] = 1'b1;
            end else if (!is_mult(pend_ff)) begin
               ef_in[F_ADD] = 1'b1;
            end
            if (op_n > OP_MOD) ef_in[F_ADD] = 1'b1;
         end else if (op_n <= OP_MINUS) begin
            sum_in = closed;
            tminus_in = op_n[0];
         end else if (!is_mult(op_n)) begin
            ef_in[F_ADD] = 1'b1;
         end
         pend_in = op_n;
         expv_in = 1'b1;
         if (cnt_ff < 2'd2) cnt_in = cnt_ff + 1'b1;
      end else begin
         ef_in[F_BAD] = 1'b1;
         if (cnt_ff < 2'd2) cnt_in = cnt_ff + 1'b1;
      end
   end

   // result from the state after the last token has been applied
   always_comb begin
      logic [W-1:0] rv;
      case (ckind_ff)
         CMP_EQ: truth = left_ff == sv;
         CMP_NE: truth = left_ff != sv;
         CMP_LT: truth = slt(left_ff, sv);
         CMP_LE: truth = !slt(sv, left_ff);
         CMP_GT: truth = slt(sv, left_ff);
         CMP_GE: truth = !slt(left_ff, sv);
         default: truth = 1'b0;
      endcase
      rv = sv;
      if (!mode_ff) begin
         ev = sv; ecode = sc; truth = 1'b0;
      end else if (ccount_ff >= 2'd2) begin
         ev = '0; ecode = ERR_MANYCMP; truth = 1'b0;
      end else if (ccount_ff == 2'd0) begin
         ev = '0; ecode = ERR_NOCMP; truth = 1'b0;
      end else if (lempty_ff || cnt_ff == 2'd0) begin
         ev = '0; ecode = ERR_MISSING; truth = 1'b0;
      end else begin
         ev = left_ff + (rv & '0);
         ecode = (lerr_ff != ERR_OK) ? lerr_ff : sc;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         ty_ff <= req_type;
         tv_ff <= req_token_value;
         op_ff <= req_op_code;
         cond_ff <= req_is_condition;
         last_ff <= req_last_token;
      end
      if (cmd.emit) begin
         out_v_ff <= ev;
         out_t_ff <= truth;
         out_e_ff <= ecode;
      end
      if (reset || cmd.emit) begin
         sum_ff <= '0; term_ff <= '0; left_ff <= '0; pend_ff <= OP_PLUS;
         expv_ff <= 1'b1; tminus_ff <= 1'b0; cnt_ff <= '0; ccount_ff <= '0;
         ckind_ff <= '0; ef_ff <= '0; lerr_ff <= ERR_OK; lempty_ff <= 1'b0;
         mode_ff <= 1'b0; start_ff <= 1'b0;
      end else if (cmd.apply) begin
         sum_ff <= sum_in; term_ff <= term_in; left_ff <= left_in; pend_ff <= pend_in;
         expv_ff <= expv_in; tminus_ff <= tminus_in; cnt_ff <= cnt_in;
         ccount_ff <= ccount_in; ckind_ff <= ckind_in; ef_ff <= ef_in;
         lerr_ff <= lerr_in; lempty_ff <= lempty_in; mode_ff <= mode_in;
         start_ff <= start_in;
      end
   end

   assign rsp_expr_value = out_v_ff;
   assign rsp_cond_true = out_t_ff;
   assign rsp_error_code = out_e_ff;

endmodule

FILE: rtl/iiee_controller.sv
// iiee_controller: token sequencing state machine and handshakes
// depends on iiee_pkg
module iiee_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 tok_last,
   input  iiee_pkg::status_type status,
   output iiee_pkg::cmd_type    cmd
);
   import iiee_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DECIDE = 5'b00010,
      S_DIV   = 5'b00100,
      S_APPLY = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic rv_ff, rv_in;

   always_comb begin
      state_in = state_ff;
      rv_in = rv_ff;
      cmd = '0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in = tok_last ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (!rv_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid) else $error("emit did not raise valid");
   a_div_only_on_need: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> status.need_div) else $error("divide without need");
   a_stall_when_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> req_stall) else $error("input open during divide");

endmodule

FILE: rtl/infix_integer_expression_evaluator_unit.sv
// infix_integer_expression_evaluator_unit: top level, controller plus datapath
// depends on iiee_pkg, iiee_controller, iiee_datapath
// one token at a time via take, decide and apply; / and % also step the divider
// after the last token, S_EMIT loads the output register, which frees the input
// synchronous active-high reset clears all evaluation state and the result valid
module infix_integer_expression_evaluator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic [iiee_pkg::VALUE_WIDTH-1:0] req_token_value,
   input  logic [3:0]                      req_op_code,
   input  logic                            req_is_condition,
   input  logic                            req_last_token,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [iiee_pkg::VALUE_WIDTH-1:0] rsp_expr_value,
   output logic                            rsp_cond_true,
   output logic [3:0]                      rsp_error_code
);
   import iiee_pkg::*;

   cmd_type cmd;
   status_type status;
   logic tok_last;

   iiee_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .tok_last(tok_last),
      .status(status), .cmd(cmd)
   );

   iiee_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_type(req_type), .req_token_value(req_token_value),
      .req_op_code(req_op_code), .req_is_condition(req_is_condition),
      .req_last_token(req_last_token), .tok_last(tok_last),
      .rsp_expr_value(rsp_expr_value), .rsp_cond_true(rsp_cond_true),
      .rsp_error_code(rsp_error_code)
   );

endmodule

FILE: bench/infix_eval_checker.sv
// infix_eval_checker: watches the token and result channels of the evaluator,
// predicts each result in its own model and compares field by field
// depends on iiee_pkg
`timescale 1ns / 1ps
module infix_eval_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [iiee_pkg::VALUE_WIDTH-1:0]  req_token_value,
   input  logic [3:0]                        req_op_code,
   input  logic                              req_is_condition,
   input  logic                              req_last_token,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [iiee_pkg::VALUE_WIDTH-1:0]  rsp_expr_value,
   input  logic                              rsp_cond_true,
   input  logic [3:0]                        rsp_error_code,
   output int                                fail_count,
   output int                                pending_count,
   output int                                result_count
);
   import iiee_pkg::*;

   typedef logic signed [VALUE_WIDTH-1:0] word_type;
   typedef struct packed {
      word_type   value;
      logic       truth;
      logic [3:0] code;
   } outcome_type;

   localparam logic [7:0] F_BAD = 8'h01, F_LEAD = 8'h02, F_MSYN = 8'h04,
      F_DIV0 = 8'h08, F_MOD0 = 8'h10, F_ADD = 8'h20, F_MULT = 8'h1C;

   outcome_type outcome_q[$];

   word_type   sum_r, term_r, left_val;
   logic [3:0] pend_op;
   logic       want_num, term_neg, mode_c, begun, left_none;
   int         side_cnt, cmp_cnt;
   logic [2:0] cmp_kind;
   logic [7:0] flags;
   logic [3:0] left_err;

   function automatic logic is_mul(logic [3:0] c);
      return c == OP_MUL || c == OP_DIV || c == OP_MOD;
   endfunction

   task automatic clear_side();
      sum_r = 0; term_r = 0; pend_op = OP_PLUS; want_num = 1;
      side_cnt = 0; flags = 0; term_neg = 0;
   endtask

   task automatic clear_all();
      clear_side();
      left_val = 0; cmp_kind = CMP_EQ; cmp_cnt = 0; left_err = ERR_OK;
      left_none = 0; mode_c = 0; begun = 0;
   endtask

   task automatic mul_fault(logic [7:0] b);
      if ((flags & F_MULT) == 0) flags |= b;
   endtask

   function automatic word_type quot(word_type a, word_type b, logic rem);
      logic [VALUE_WIDTH-1:0] ma, mb, r;
      ma = a[VALUE_WIDTH-1] ? -a : a;
      mb = b[VALUE_WIDTH-1] ? -b : b;
      if (rem) begin
         r = ma % mb;
         return a[VALUE_WIDTH-1] ? -r : r;
      end
      r = ma / mb;
      return (a[VALUE_WIDTH-1] != b[VALUE_WIDTH-1]) ? -r : r;
   endfunction

   task automatic close_side(output word_type v, output logic [3:0] c);
      v = 0;
      if (flags & F_BAD) c = ERR_BAD;
      else if ((flags & F_LEAD) || want_num) c = ERR_LEAD;
      else if (flags & F_MSYN) c = ERR_SYNTAX;
      else if (flags & F_DIV0) c = ERR_DIV0;
      else if (flags & F_MOD0) c = ERR_MOD0;
      else if (flags & F_ADD) c = ERR_SYNTAX;
      else begin
         c = ERR_OK;
         v = term_neg ? sum_r - term_r : sum_r + term_r;
      end
   endtask

   function automatic logic compare_words(logic [2:0] k, word_type a, word_type b);
      case (k)
         CMP_EQ: return a == b;
         CMP_NE: return a != b;
         CMP_LT: return a < b;
         CMP_LE: return a <= b;
         CMP_GT: return a > b;
         CMP_GE: return a >= b;
         default: return 0;
      endcase
   endfunction

   task automatic apply_token(logic [1:0] ty, word_type v, logic [3:0] op_in, logic cnd,
                              logic fin);
      logic [3:0] op, lc, rc;
      word_type rv;
      outcome_type o;
      op = op_in > OP_OTHER ? OP_OTHER : op_in;
      if (!begun) begin
         begun = 1; mode_c = cnd;
      end
      if (mode_c && ty == TYPE_OP && op >= OP_EQ && op <= OP_GE) begin
         if (cmp_cnt == 0) begin
            left_none = side_cnt == 0;
            close_side(left_val, lc);
            left_err = lc;
            cmp_kind = 3'(op - OP_EQ);
            cmp_cnt = 1;
            clear_side();
         end else cmp_cnt = 2;
      end else if (mode_c && cmp_cnt >= 2) begin
      end else if (ty == TYPE_NUMBER) begin
         if (side_cnt == 0) begin
            sum_r = 0; term_neg = 0; term_r = v;
         end else if (!want_num) begin
            flags |= F_ADD; term_r = v;
         end else if (is_mul(pend_op)) begin
            if (pend_op == OP_MUL) term_r = term_r * v;
            else if (v == 0) mul_fault(pend_op == OP_DIV ? F_DIV0 : F_MOD0);
            else term_r = quot(term_r, v, pend_op == OP_MOD);
         end else term_r = v;
         want_num = 0;
         if (side_cnt < 2) side_cnt++;
      end else if (ty == TYPE_OP) begin
         if (side_cnt == 0) flags |= F_LEAD;
         else if (want_num) begin
            if (is_mul(pend_op)) mul_fault(F_MSYN);
            if (is_mul(op)) mul_fault(F_MSYN);
            else if (!is_mul(pend_op)) flags |= F_ADD;
            if (op > OP_MOD) flags |= F_ADD;
         end else if (op <= OP_MINUS) begin
            sum_r = term_neg ? sum_r - term_r : sum_r + term_r;
            term_neg = op[0];
         end else if (!is_mul(op)) flags |= F_ADD;
         pend_op = op;
         want_num = 1;
         if (side_cnt < 2) side_cnt++;
      end else begin
         flags |= F_BAD;
         if (side_cnt < 2) side_cnt++;
      end
      if (!fin) return;
      o = '0;
      if (!mode_c) close_side(o.value, o.code);
      else if (cmp_cnt >= 2) o.code = ERR_MANYCMP;
      else if (cmp_cnt == 0) o.code = ERR_NOCMP;
      else if (left_none || side_cnt == 0) o.code = ERR_MISSING;
      else begin
         close_side(rv, rc);
         o.value = left_val;
         o.truth = compare_words(cmp_kind, left_val, rv);
         o.code = left_err != ERR_OK ? left_err : rc;
      end
      outcome_q = {outcome_q, o};
      clear_all();
   endtask

   initial clear_all();

   assign pending_count = outcome_q.size();

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            apply_token(req_type, req_token_value, req_op_code, req_is_condition,
                        req_last_token);
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (outcome_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result transfer at %0t", $realtime);
            end else begin
               e = outcome_q.pop_front();
               if (e.value !== rsp_expr_value || e.truth !== rsp_cond_true ||
                   e.code !== rsp_error_code) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected %0d/%0b/%0d got %0d/%0b/%0d",
                              e.value, e.truth, e.code, $signed(rsp_expr_value),
                              rsp_cond_true, rsp_error_code);
               end
            end
         end
      end
   end
endmodule

FILE: bench/tb_infix_integer_expression_evaluator_unit.sv
// tb_infix_integer_expression_evaluator_unit: drives token streams into the
// evaluator with random idling and hold-offs; depends on iiee_pkg, the unit and the checker
`timescale 1ns / 1ps
module tb_infix_integer_expression_evaluator_unit;
   import iiee_pkg::*;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   logic [1:0] req_type = TYPE_NUMBER;
   logic [VALUE_WIDTH-1:0] req_token_value = 0;
   logic [3:0] req_op_code = OP_PLUS;
   logic req_is_condition = 0, req_last_token = 0;
   logic [VALUE_WIDTH-1:0] rsp_expr_value;
   logic rsp_cond_true;
   logic [3:0] rsp_error_code;
   int fail_count, pending_count, result_count;
   int sent = 0;
   logic calm = 0, hold_rsp = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   infix_integer_expression_evaluator_unit dut (.*);

   infix_eval_checker chk (.*);

   always @(posedge clock)
      rsp_stall <= hold_rsp || (!calm && $urandom_range(99) < 20);

   // valid stays high after a transfer until the next token or an idle cycle
   task automatic send(logic [1:0] ty, logic [31:0] v, logic [3:0] op, logic cnd, logic fin);
      while (!calm && $urandom_range(99) < 20) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_type <= ty; req_token_value <= v; req_op_code <= op;
      req_is_condition <= cnd; req_last_token <= fin;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(3) - 1;
         3: return $urandom;
         default: return $urandom_range(40) - 20;
      endcase
   endfunction

   task automatic rand_side(logic cnd);
      int n;
      n = $urandom_range(4);
      send(TYPE_NUMBER, rand_value(), OP_PLUS, cnd, 0);
      repeat (n) begin
         send(TYPE_OP, 0, 4'($urandom_range(OP_MOD)), cnd, 0);
         send(TYPE_NUMBER, rand_value(), OP_PLUS, cnd, 0);
      end
   endtask

   task automatic rand_expr();
      int k, n;
      logic cnd;
      cnd = 1'($urandom_range(1));
      k = $urandom_range(9);
      if (k < 7) begin
         rand_side(cnd);
         if (cnd) begin
            send(TYPE_OP, 0, 4'(OP_EQ + $urandom_range(5)), cnd, 0);
            rand_side(cnd);
         end
         send(TYPE_OP, 0, OP_PLUS, cnd, 0);
         send(TYPE_NUMBER, rand_value(), OP_PLUS, cnd, 1);
      end else begin
         n = $urandom_range(5);
         repeat (n) send(2'($urandom), $urandom, 4'($urandom), 1'($urandom_range(1)), 0);
         send(2'($urandom), $urandom, 4'($urandom), 1'($urandom_range(1)), 1);
      end
   endtask

   initial begin
      #2_000_000;
      $display("tb_infix_integer_expression_evaluator_unit: errors");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send(TYPE_NUMBER, 32'h7FFF_FFFF, OP_PLUS, 0, 1);
      send(TYPE_OP, 0, OP_PLUS, 0, 1);
      send(TYPE_BAD, 0, OP_PLUS, 0, 1);
      send(TYPE_SPARE, 0, OP_PLUS, 0, 1);
      send(TYPE_NUMBER, 32'h8000_0000, OP_PLUS, 0, 0);
      send(TYPE_OP, 0, OP_DIV, 0, 0);
      send(TYPE_NUMBER, 32'hFFFF_FFFF, OP_PLUS, 0, 1);
      send(TYPE_NUMBER, 32'h8000_0000, OP_PLUS, 0, 0);
      send(TYPE_OP, 0, OP_MOD, 0, 0);
      send(TYPE_NUMBER, 32'hFFFF_FFFF, OP_PLUS, 0, 1);
      send(TYPE_NUMBER, 7, OP_PLUS, 0, 0);
      send(TYPE_OP, 0, OP_DIV, 0, 0);
      send(TYPE_NUMBER, 0, OP_PLUS, 0, 1);
      send(TYPE_NUMBER, 7, OP_PLUS, 1, 0);
      send(TYPE_OP, 0, OP_MOD, 0, 0);
      send(TYPE_NUMBER, 0, OP_PLUS, 0, 1);
      send(TYPE_NUMBER, 3, OP_PLUS, 1, 0);
      send(TYPE_OP, 0, OP_GE, 1, 0);
      send(TYPE_OP, 0, OP_EQ, 1, 0);
      send(TYPE_NUMBER, 3, OP_PLUS, 1, 1);
      send(TYPE_NUMBER, 3, OP_PLUS, 1, 0);
      send(TYPE_OP, 0, OP_SPARE_HI, 1, 1);
      send(TYPE_OP, 0, OP_LE, 1, 0);
      send(TYPE_NUMBER, 3, OP_PLUS, 1, 1);
      // random, first with no idling
      calm = 1;
      repeat (20) rand_expr();
      calm = 0;
      while (sent < 200) rand_expr();
      // receiver hold-off while tokens keep coming
      hold_rsp = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         repeat (6) rand_expr();
      join
      // sender pause until drained
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      while (sent < 550) rand_expr();
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d tokens, checked %0d results across both modes", sent, result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_infix_integer_expression_evaluator_unit: clean");
      else
         $display("tb_infix_integer_expression_evaluator_unit: errors");
      $finish;
   end
endmodule
